@@ hw/rtl/acf_pkg.sv @@
// ----------------------------------------------------------------------------
// acf_pkg
// Shared types and constants for the accumulator cpu fetch/execute unit.
// ----------------------------------------------------------------------------
package acf_pkg;

    localparam int DEF_ADDR_WIDTH = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // instruction opcodes
    localparam logic [7:0] OP_READ       = 8'h10;
    localparam logic [7:0] OP_WRITE      = 8'h11;
    localparam logic [7:0] OP_LOAD       = 8'h20;
    localparam logic [7:0] OP_STORE      = 8'h21;
    localparam logic [7:0] OP_ADD        = 8'h30;
    localparam logic [7:0] OP_SUB        = 8'h31;
    localparam logic [7:0] OP_DIV        = 8'h32;
    localparam logic [7:0] OP_MUL        = 8'h33;
    localparam logic [7:0] OP_BRANCH     = 8'h40;
    localparam logic [7:0] OP_BRANCHNEG  = 8'h41;
    localparam logic [7:0] OP_BRANCHZERO = 8'h42;
    localparam logic [7:0] OP_HALT       = 8'h43;

    // step phase codes
    localparam logic [2:0] PH_OPC  = 3'd0;
    localparam logic [2:0] PH_HIGH = 3'd1;
    localparam logic [2:0] PH_LOW  = 3'd2;
    localparam logic [2:0] PH_EXEC = 3'd3;
    localparam logic [2:0] PH_NEXT = 3'd4;

    typedef enum logic
    {
        ST_IDLE,
        ST_WAIT
    } state_t;

    // request to the multiply/divide unit
    typedef struct packed
    {
        logic start;
        logic is_div;
    } muldiv_req_t;

    // status from the multiply/divide unit
    typedef struct packed
    {
        logic busy;
        logic done;
    } muldiv_rsp_t;

endpackage

@@ hw/rtl/accumulator_cpu_fetch_execute_unit.sv @@
// ----------------------------------------------------------------------------
// accumulator_cpu_fetch_execute_unit
// Cycle-level accumulator cpu: one bus tick per input transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one clock tick of the cpu and carries the word the
// memory returned for the address driven on the previous tick plus a console
// value; each one yields exactly one output transaction with the address and
// write strobe for the next tick, the bus drive, the accumulator, console
// output, halt flag and phase. The execute tick of mul or div runs through
// the shared add/subtract unit in acf_muldiv, while s_tready is low. Division
// by zero halts without starting the unit. A new input transaction is taken
// only while the output register is empty or its result is accepted in the
// same cycle, so a result waiting on m_tready holds off the input. The first
// tick after reset only starts the cpu; after halt the state freezes until
// reset.
// ----------------------------------------------------------------------------
module accumulator_cpu_fetch_execute_unit
    import acf_pkg::*;
#(
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int IN_W      = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW   = ADDR_WIDTH + 3 * DATA_WIDTH + 5,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    // input transactions
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // bus_word, console_value
    // output transactions
    output logic             m_tvalid,
    input  logic             m_tready,
    // mem_address, mem_write, drive_value, acc_value, console_out, halted, phase
    output logic [OUT_W-1:0] m_tdata,
    output logic [1:0]       m_tuser    // drive_valid, console_valid
);

    localparam int AW = ADDR_WIDTH;
    localparam int DW = DATA_WIDTH;

    // input fields
    logic [DW-1:0] bus_word;
    logic [DW-1:0] console_value;
    logic          in_xfer;

    // architectural state
    state_t        state_reg, state_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic [AW-1:0] ip_reg, ip_next;
    logic [7:0]    op_reg, op_next;
    logic [7:0]    addr_high_reg, addr_high_next;
    logic [AW-1:0] bus_addr_reg, bus_addr_next;
    logic          wflag_reg, wflag_next;
    logic [2:0]    phase_reg, phase_next;
    logic          started_reg, started_next;
    logic          running_reg, running_next;

    // output register
    logic          m_tvalid_reg, m_tvalid_next;
    logic [AW-1:0] o_addr_reg;
    logic          o_wflag_reg;
    logic          o_dv_reg;
    logic [DW-1:0] o_dval_reg;
    logic [DW-1:0] o_acc_reg;
    logic          o_cv_reg;
    logic [DW-1:0] o_cout_reg;
    logic          o_halted_reg;
    logic [2:0]    o_phase_reg;

    // per-tick bus and console results
    logic          dv;
    logic [DW-1:0] dval;
    logic          cv;
    logic [DW-1:0] cout;
    logic          load_out;
    logic [AW+15:0] operand_addr;

    // multiply/divide unit
    muldiv_req_t   md_req;
    muldiv_rsp_t   md_rsp;
    logic [DW-1:0] md_result;

    assign bus_word      = s_tdata[DW-1:0];
    assign console_value = s_tdata[2*DW-1:DW];
    assign s_tready      = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_xfer       = s_tvalid && s_tready;
    // operand address from the two fetched bytes, fitted to the address width
    assign operand_addr  = {{AW{1'b0}}, addr_high_reg, bus_word[7:0]};

    acf_muldiv #(
        .DATA_WIDTH (DW)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .op_a   (acc_reg),
        .op_b   (bus_word),
        .rsp    (md_rsp),
        .result (md_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        ip_next        = ip_reg;
        op_next        = op_reg;
        addr_high_next = addr_high_reg;
        bus_addr_next  = bus_addr_reg;
        wflag_next     = wflag_reg;
        phase_next     = phase_reg;
        started_next   = started_reg;
        running_next   = running_reg;
        dv             = 1'b0;
        dval           = '0;
        cv             = 1'b0;
        cout           = '0;
        load_out       = 1'b0;
        md_req         = '0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    load_out = 1'b1;
                    if (!started_reg)
                    begin
                        // first tick after reset only wakes the cpu
                        started_next = 1'b1;
                    end
                    else if (running_reg)
                    begin
                        case (phase_reg)
                            PH_HIGH:
                            begin
                                addr_high_next = bus_word[7:0];
                                ip_next        = ip_reg + 1'b1;
                                bus_addr_next  = ip_reg + 1'b1;
                                phase_next     = PH_LOW;
                            end
                            PH_LOW:
                            begin
                                ip_next       = ip_reg + 1'b1;
                                bus_addr_next = operand_addr[AW-1:0];
                                phase_next    = PH_EXEC;
                            end
                            PH_EXEC:
                            begin
                                phase_next = PH_NEXT;
                                case (op_reg)
                                    OP_READ:
                                    begin
                                        dv         = 1'b1;
                                        dval       = console_value;
                                        wflag_next = 1'b1;
                                    end
                                    OP_WRITE:
                                    begin
                                        cv   = 1'b1;
                                        cout = bus_word;
                                    end
                                    OP_LOAD:
                                    begin
                                        acc_next   = bus_word;
                                        wflag_next = 1'b0;
                                    end
                                    OP_STORE:
                                    begin
                                        dv         = 1'b1;
                                        dval       = acc_reg;
                                        wflag_next = 1'b1;
                                    end
                                    OP_ADD:        acc_next = acc_reg + bus_word;
                                    OP_SUB:        acc_next = acc_reg - bus_word;
                                    OP_DIV:
                                    begin
                                        if (bus_word != '0)
                                        begin
                                            md_req.start  = 1'b1;
                                            md_req.is_div = 1'b1;
                                            load_out      = 1'b0;
                                            state_next    = ST_WAIT;
                                        end
                                        else
                                        begin
                                            // divide by zero stops the cpu
                                            running_next = 1'b0;
                                        end
                                    end
                                    OP_MUL:
                                    begin
                                        md_req.start = 1'b1;
                                        load_out     = 1'b0;
                                        state_next   = ST_WAIT;
                                    end
                                    OP_BRANCH:     ip_next = bus_addr_reg;
                                    OP_BRANCHNEG:
                                    begin
                                        if (acc_reg[DW-1])
                                        begin
                                            ip_next = bus_addr_reg;
                                        end
                                    end
                                    OP_BRANCHZERO:
                                    begin
                                        if (acc_reg == '0)
                                        begin
                                            ip_next = bus_addr_reg;
                                        end
                                    end
                                    OP_HALT:       running_next = 1'b0;
                                    default:       ;
                                endcase
                            end
                            PH_NEXT:
                            begin
                                bus_addr_next = ip_reg;
                                wflag_next    = 1'b0;
                                phase_next    = PH_OPC;
                            end
                            default:
                            begin
                                // opcode fetch, also taken for unused phase codes
                                op_next       = bus_word[7:0];
                                ip_next       = ip_reg + 1'b1;
                                bus_addr_next = ip_reg + 1'b1;
                                phase_next    = PH_HIGH;
                            end
                        endcase
                    end
                end
            end
            ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    acc_next   = md_result;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            ip_reg        <= '0;
            op_reg        <= '0;
            addr_high_reg <= '0;
            bus_addr_reg  <= '0;
            wflag_reg     <= 1'b0;
            phase_reg     <= PH_OPC;
            started_reg   <= 1'b0;
            running_reg   <= 1'b1;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            ip_reg        <= ip_next;
            op_reg        <= op_next;
            addr_high_reg <= addr_high_next;
            bus_addr_reg  <= bus_addr_next;
            wflag_reg     <= wflag_next;
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            running_reg   <= running_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // result payload, shows the state after the tick
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_addr_reg   <= bus_addr_next;
            o_wflag_reg  <= wflag_next;
            o_dv_reg     <= dv;
            o_dval_reg   <= dval;
            o_acc_reg    <= acc_next;
            o_cv_reg     <= cv;
            o_cout_reg   <= cout;
            o_halted_reg <= !running_next;
            o_phase_reg  <= phase_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({o_phase_reg, o_halted_reg, o_cout_reg, o_acc_reg,
                              o_dval_reg, o_wflag_reg, o_addr_reg});
    assign m_tuser  = {o_cv_reg, o_dv_reg};

    // unit finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (state_reg == ST_WAIT))
        else $error("muldiv done outside wait state");

    // a finished product or quotient always finds the output register free
    assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> !m_tvalid_reg)
        else $error("muldiv result would overwrite pending output");

    // once halted the cpu stays halted
    assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |=> !running_reg)
        else $error("cpu resumed after halt");

    // no new transaction while the unit is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.busy |-> !s_tready)
        else $error("input accepted while muldiv busy");

endmodule

@@ hw/rtl/acf_muldiv.sv @@
// ----------------------------------------------------------------------------
// acf_muldiv
// Iterative multiply and signed divide around one shared add/subtract unit.
// ----------------------------------------------------------------------------
module acf_muldiv
    import acf_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  muldiv_req_t           req,
    input  logic [DATA_WIDTH-1:0] op_a,
    input  logic [DATA_WIDTH-1:0] op_b,
    output muldiv_rsp_t           rsp,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int SW = DATA_WIDTH + 2;
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  active_reg, active_next;
    logic                  fin_reg, fin_next;
    logic                  div_reg, div_next;
    logic                  neg_reg, neg_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] opx_reg, opx_next;
    logic [DATA_WIDTH-1:0] opy_reg, opy_next;

    logic [SW-1:0]         add_a;
    logic [SW-1:0]         add_b;
    logic                  add_sub;
    logic [SW-1:0]         add_sum;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;

    // shared adder: product accumulate, trial subtract, final negate
    always_comb
    begin
        if (fin_reg)
        begin
            add_a   = '0;
            add_b   = {2'b00, opy_reg};
            add_sub = 1'b1;
        end
        else if (div_reg)
        begin
            add_a   = {1'b0, rem_reg, opy_reg[DATA_WIDTH-1]};
            add_b   = {2'b00, opx_reg};
            add_sub = 1'b1;
        end
        else
        begin
            add_a   = {2'b00, rem_reg};
            add_b   = opy_reg[0] ? {2'b00, opx_reg} : '0;
            add_sub = 1'b0;
        end
        add_sum = add_a + (add_sub ? ~add_b : add_b) + SW'(add_sub);
    end

    assign mag_a = op_a[DATA_WIDTH-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[DATA_WIDTH-1] ? (~op_b + 1'b1) : op_b;

    always_comb
    begin
        active_next = active_reg;
        fin_next    = 1'b0;
        div_next    = div_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        opx_next    = opx_reg;
        opy_next    = opy_reg;

        if (req.start)
        begin
            active_next = 1'b1;
            div_next    = req.is_div;
            cnt_next    = CW'(DATA_WIDTH);
            rem_next    = '0;
            if (req.is_div)
            begin
                opx_next = mag_b;
                opy_next = mag_a;
                neg_next = op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
            end
            else
            begin
                opx_next = op_a;
                opy_next = op_b;
                neg_next = 1'b0;
            end
        end
        else if (active_reg)
        begin
            if (div_reg)
            begin
                // restoring step, quotient bits shift in behind the dividend
                if (!add_sum[SW-1])
                begin
                    rem_next = add_sum[DATA_WIDTH-1:0];
                    opy_next = {opy_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[DATA_WIDTH-2:0], opy_reg[DATA_WIDTH-1]};
                    opy_next = {opy_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                rem_next = add_sum[DATA_WIDTH-1:0];
                opx_next = {opx_reg[DATA_WIDTH-2:0], 1'b0};
                opy_next = {1'b0, opy_reg[DATA_WIDTH-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                active_next = 1'b0;
                fin_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            fin_reg    <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        opx_reg <= opx_next;
        opy_reg <= opy_next;
    end

    assign rsp.busy = active_reg | fin_reg;
    assign rsp.done = fin_reg;
    assign result   = div_reg ? (neg_reg ? add_sum[DATA_WIDTH-1:0] : opy_reg) : rem_reg;

endmodule

@@ sim/tb_accumulator_cpu_fetch_execute_unit.sv @@
// ----------------------------------------------------------------------------
// tb_accumulator_cpu_fetch_execute_unit
// Self-checking bench for the accumulator cpu: every input transaction is one
// cpu tick, a tick-level predictor builds the expected output transaction
// and a scoreboard compares it field by field with what the unit returns.
// Stimulus is mostly well-formed instruction streams with random content,
// with random gaps and stalls on both sides of the unit.
// ----------------------------------------------------------------------------
module tb_accumulator_cpu_fetch_execute_unit;
    import acf_pkg::*;

    localparam int IN_W         = 64;
    localparam int OUT_W        = 120;
    localparam int RANDOM_TICKS = 620;
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 30;

    // one output transaction, unpacked
    typedef struct
    {
        logic [15:0] mem_address;
        logic        mem_write;
        logic        drive_valid;
        logic [31:0] drive_value;
        logic [31:0] acc_value;
        logic        console_valid;
        logic [31:0] console_out;
        logic        halted;
        logic [2:0]  phase;
    } cpu_tick_t;

    // predictor of the cpu plus the queue of ticks it still expects
    class cpu_tick_checker;
        logic [31:0] acc;
        logic [15:0] ip;
        logic [7:0]  opcode;
        logic [7:0]  addr_hi;
        logic [15:0] bus_addr;
        logic        wr_flag;
        logic [2:0]  phase;
        logic        started;
        logic        running;
        cpu_tick_t   expected_ticks[$];
        int          errors;

        function new();
            acc      = '0;
            ip       = '0;
            opcode   = '0;
            addr_hi  = '0;
            bus_addr = '0;
            wr_flag  = 1'b0;
            phase    = PH_OPC;
            started  = 1'b0;
            running  = 1'b1;
            errors   = 0;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // truncating signed divide; most negative over -1 wraps to itself
        function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q  = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void note_tick(logic [31:0] word, logic [31:0] cons);
            cpu_tick_t t;
            t = '{default: '0};
            if (!started)
            begin
                started = 1'b1;
            end
            else if (running)
            begin
                case (phase)
                    PH_HIGH:
                    begin
                        addr_hi  = word[7:0];
                        ip       = ip + 16'd1;
                        bus_addr = ip;
                        phase    = PH_LOW;
                    end
                    PH_LOW:
                    begin
                        ip       = ip + 16'd1;
                        bus_addr = {addr_hi, word[7:0]};
                        phase    = PH_EXEC;
                    end
                    PH_EXEC:
                    begin
                        case (opcode)
                            OP_READ:
                            begin
                                t.drive_valid = 1'b1;
                                t.drive_value = cons;
                                wr_flag       = 1'b1;
                            end
                            OP_WRITE:
                            begin
                                t.console_valid = 1'b1;
                                t.console_out   = word;
                            end
                            OP_LOAD:
                            begin
                                acc     = word;
                                wr_flag = 1'b0;
                            end
                            OP_STORE:
                            begin
                                t.drive_valid = 1'b1;
                                t.drive_value = acc;
                                wr_flag       = 1'b1;
                            end
                            OP_ADD:       acc = acc + word;
                            OP_SUB:       acc = acc - word;
                            OP_DIV:
                            begin
                                if (word != 0)
                                    acc = quotient(acc, word);
                                else
                                    running = 1'b0;
                            end
                            OP_MUL:       acc = acc * word;
                            OP_BRANCH:    ip = bus_addr;
                            OP_BRANCHNEG:
                            begin
                                if (acc[31])
                                    ip = bus_addr;
                            end
                            OP_BRANCHZERO:
                            begin
                                if (acc == 0)
                                    ip = bus_addr;
                            end
                            OP_HALT:      running = 1'b0;
                            default:      ;
                        endcase
                        phase = PH_NEXT;
                    end
                    PH_NEXT:
                    begin
                        bus_addr = ip;
                        wr_flag  = 1'b0;
                        phase    = PH_OPC;
                    end
                    default:
                    begin
                        opcode   = word[7:0];
                        ip       = ip + 16'd1;
                        bus_addr = ip;
                        phase    = PH_HIGH;
                    end
                endcase
            end
            t.mem_address = bus_addr;
            t.mem_write   = wr_flag;
            t.acc_value   = acc;
            t.halted      = !running;
            t.phase       = phase;
            expected_ticks.push_back(t);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        endtask

        task check_result(logic [OUT_W-1:0] data, logic [1:0] user);
            cpu_tick_t want;
            if (expected_ticks.size() == 0)
            begin
                report("unexpected transaction", data[31:0], '0);
                return;
            end
            want = expected_ticks.pop_front();
            if (data[15:0] !== want.mem_address)
                report("mem_address", 32'(data[15:0]), 32'(want.mem_address));
            if (data[16] !== want.mem_write)
                report("mem_write", 32'(data[16]), 32'(want.mem_write));
            if (data[48:17] !== want.drive_value)
                report("drive_value", data[48:17], want.drive_value);
            if (data[80:49] !== want.acc_value)
                report("acc_value", data[80:49], want.acc_value);
            if (data[112:81] !== want.console_out)
                report("console_out", data[112:81], want.console_out);
            if (data[113] !== want.halted)
                report("halted", 32'(data[113]), 32'(want.halted));
            if (data[116:114] !== want.phase)
                report("phase", 32'(data[116:114]), 32'(want.phase));
            if (data[119:117] !== 3'b000)
                report("tdata padding", 32'(data[119:117]), '0);
            if (user[0] !== want.drive_valid)
                report("drive_valid", 32'(user[0]), 32'(want.drive_valid));
            if (user[1] !== want.console_valid)
                report("console_valid", 32'(user[1]), 32'(want.console_valid));
        endtask
    endclass

    logic            clk      = 1'b0;
    logic            rst_n    = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata  = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]      m_tuser;

    cpu_tick_checker book = new();

    // every opcode except halt; halt and divide by zero freeze the cpu until
    // reset, so they only appear at the very end of the run
    logic [7:0] run_ops [11] = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD,
                                 OP_SUB, OP_DIV, OP_MUL, OP_BRANCH,
                                 OP_BRANCHNEG, OP_BRANCHZERO};

    int quiet_sends = 0;
    int ready_hold  = 0;
    int cycles      = 0;

    accumulator_cpu_fetch_execute_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // output side: random stalls, mostly short, a few long, and some
    // stretches with m_tready held high
    always @(negedge clk)
    begin
        int r;
        if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(30, 80);
            end
            else if (r < 65)
            begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(0, 3);
            end
            else if (r < 92)
            begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end
            else
            begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    // result check on every accepted output transaction, plus the watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && m_tvalid && m_tready)
            book.check_result(m_tdata, m_tuser);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_accumulator_cpu_fetch_execute_unit failed");
            $finish;
        end
    end

    // idle cycles before the next input transaction
    function int sender_gap();
        int r;
        if (quiet_sends > 0)
        begin
            quiet_sends--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_sends = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // extremes and small values, which make branches and overflow likely
    function logic [31:0] edge_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h0000_0000;
            1:       v = 32'h0000_0001;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h8000_0000;
            4:       v = 32'h7FFF_FFFF;
            5, 6:
            begin
                v = $urandom_range(0, 16);
                v = v - 32'd8;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // bus word for the phase the cpu is about to run
    function logic [31:0] pick_word();
        logic [31:0] w;
        int          r;
        w = $urandom;
        if (!book.started)
            return w;
        case (book.phase)
            PH_OPC:
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    w[7:0] = run_ops[$urandom_range(0, 10)];
                else if (w[7:0] == OP_HALT)
                    w[7:0] = OP_LOAD;
            end
            PH_EXEC:
            begin
                w = edge_value();
                if (book.opcode == OP_DIV && w == 0)
                    w = 32'h0000_0003;
            end
            default: ;
        endcase
        return w;
    endfunction

    // one cpu tick: optional gap, then hold the transaction until accepted
    task send_tick(input logic [31:0] word, input logic [31:0] cons);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cons, word};
        do
            @(posedge clk);
        while (!s_tready);
        book.note_tick(word, cons);
        @(negedge clk);
    endtask

    // one full instruction: opcode, two address bytes, execute, next
    task run_instr(input logic [7:0] op, input logic [31:0] hi_word,
                   input logic [31:0] lo_word, input logic [31:0] operand,
                   input logic [31:0] cons);
        logic [31:0] noise;
        noise = $urandom;
        send_tick({noise[31:8], op}, $urandom);
        send_tick(hi_word, $urandom);
        send_tick(lo_word, $urandom);
        send_tick(operand, cons);
        send_tick($urandom, $urandom);
    endtask

    // hold off input until every expected transaction has come back
    task drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (book.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first tick after reset is idle
        send_tick(32'hFFFF_FFFF, 32'h8000_0000);
        // most negative value over -1, then wrapping multiply
        run_instr(OP_LOAD, 32'hFFFF_FF80, 32'hFFFF_FF00, 32'h8000_0000, 32'h0);
        run_instr(OP_DIV, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
        run_instr(OP_MUL, 32'h0000_007F, 32'h0000_00FF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        // both bus drives with extreme values
        run_instr(OP_STORE, 32'h0000_0012, 32'h0000_0034, 32'h0, 32'h8000_0000);
        run_instr(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);

        // random instruction streams, with a full drain halfway through
        for (int i = 0; i < RANDOM_TICKS; i++)
        begin
            if (i == RANDOM_TICKS / 2)
                drain_results();
            send_tick(pick_word(), edge_value());
        end

        // finish the current instruction, then divide by zero to halt for good
        while (book.phase != PH_OPC)
            send_tick(pick_word(), edge_value());
        run_instr(OP_DIV, 32'h0000_00AB, 32'h0000_00CD, 32'h0, 32'h1);
        // frozen cpu ignores further ticks, a halt opcode included
        send_tick({24'hFFFFFF, OP_HALT}, $urandom);
        repeat (4) send_tick($urandom, $urandom);
        s_tvalid <= 1'b0;

        while (book.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (book.errors == 0)
            $display("tb_accumulator_cpu_fetch_execute_unit passed");
        else
            $display("tb_accumulator_cpu_fetch_execute_unit failed");
        $finish;
    end

endmodule
